// File: hw/rtl/fxalu_pkg.sv
package fxalu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = WORD_BITS + FRAC_BITS;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int RV_W      = PROD_W + 1 - FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  // Decode, multiply, one stage per quotient bit, round, output.
  localparam int N_STAGES  = DIV_STEPS + 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_I2F  = 4'd8,
    OP_F2I  = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]                  operation;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result;
    logic                        less;
    logic                        equal;
    logic                        greater;
    logic                        div_by_zero;
  } out_t;

  typedef struct packed {
    logic [3:0]           op;
    logic [WORD_BITS-1:0] res;
    logic                 lt;
    logic                 eq;
    logic                 gt;
    logic                 dz;
    logic                 neg;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] d;
    logic [NUM_W-1:0]     num;
    logic [WORD_BITS-1:0] rem;
    logic [NUM_W-1:0]     q;
    logic [PROD_W-1:0]    prod;
    logic [RV_W-1:0]      rv;
  } pipe_t;

endpackage

// File: hw/rtl/fixed_point_q24_8_alu_unit.sv
// Channel  | Ports                            | Moves
// ---------+----------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data      | opcode and two operands
// result   | out_valid, out_ready, out_data   | result and compare/zero flags
//
// One transfer per cycle in both directions while results are taken; every
// operation passes decode, multiply, one divider stage per quotient bit (40),
// rounding and output stages in that order.
// Synchronous active-low reset empties the pipeline; payload is not reset.
// When the output holds a result that is not taken, the whole pipeline holds.
module fixed_point_q24_8_alu_unit
  import fxalu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int LAST = N_STAGES - 1;
  localparam logic [RV_W-1:0] POS_MAX = RV_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [RV_W-1:0] NEG_MAG = RV_W'(64'd1 << (WORD_BITS - 1));

  logic  [N_STAGES-1:0] vld_r, vld_nxt;
  pipe_t                st_r   [0:LAST-1];
  pipe_t                st_nxt [0:LAST-1];
  out_t                 out_r, out_nxt;
  logic                 adv;

  assign adv       = !vld_r[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAST];
  assign out_data  = out_r;
  assign vld_nxt   = {vld_r[LAST-1:0], in_valid};

  always_comb begin
    pipe_t p;
    logic signed [WORD_BITS-1:0] a, b;
    logic [WORD_BITS:0] rs;
    logic round_up;
    logic [RV_W-1:0] v;
    a = in_data.operand_a;
    b = in_data.operand_b;
    p = '0;
    p.op  = in_data.operation;
    p.lt  = a < b;
    p.eq  = a == b;
    p.gt  = a > b;
    p.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    p.ma  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    p.d   = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
    p.num = {p.ma, {FRAC_BITS{1'b0}}};
    p.dz  = (in_data.operation == OP_DIV) && (b == '0);
    case (in_data.operation)
      OP_ADD:  p.res = WORD_BITS'(a + b);
      OP_SUB:  p.res = WORD_BITS'(a - b);
      OP_MIN:  p.res = (a <= b) ? a : b;
      OP_MAX:  p.res = (a >= b) ? a : b;
      OP_INC:  p.res = WORD_BITS'(a + 1);
      OP_DEC:  p.res = WORD_BITS'(a - 1);
      OP_I2F:  p.res = a <<< FRAC_BITS;
      OP_F2I:  p.res = a >>> FRAC_BITS;
      default: p.res = '0;
    endcase
    st_nxt[0] = p;

    st_nxt[1] = st_r[0];
    st_nxt[1].prod = PROD_W'(st_r[0].ma) * PROD_W'(st_r[0].d);

    // Restoring division, one quotient bit per stage.
    for (int k = 0; k < DIV_STEPS; k++) begin
      st_nxt[k+2] = st_r[k+1];
      rs = {st_r[k+1].rem, st_r[k+1].num[NUM_W-1]};
      st_nxt[k+2].num = {st_r[k+1].num[NUM_W-2:0], 1'b0};
      if (rs >= {1'b0, st_r[k+1].d}) begin
        st_nxt[k+2].rem = WORD_BITS'(rs - {1'b0, st_r[k+1].d});
        st_nxt[k+2].q   = {st_r[k+1].q[NUM_W-2:0], 1'b1};
      end else begin
        st_nxt[k+2].rem = rs[WORD_BITS-1:0];
        st_nxt[k+2].q   = {st_r[k+1].q[NUM_W-2:0], 1'b0};
      end
    end

    // Round half away from zero on magnitudes.
    st_nxt[LAST-1] = st_r[LAST-2];
    round_up = {st_r[LAST-2].rem, 1'b0} >= {1'b0, st_r[LAST-2].d};
    if (st_r[LAST-2].op == OP_MUL)
      st_nxt[LAST-1].rv = RV_W'(({1'b0, st_r[LAST-2].prod}
                                 + (PROD_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    else
      st_nxt[LAST-1].rv = RV_W'(st_r[LAST-2].q) + RV_W'(round_up);

    v = st_r[LAST-1].rv;
    out_nxt.less        = st_r[LAST-1].lt;
    out_nxt.equal       = st_r[LAST-1].eq;
    out_nxt.greater     = st_r[LAST-1].gt;
    out_nxt.div_by_zero = st_r[LAST-1].dz;
    if ((st_r[LAST-1].op == OP_MUL || st_r[LAST-1].op == OP_DIV) && !st_r[LAST-1].dz) begin
      if (st_r[LAST-1].neg)
        out_nxt.result = (v > NEG_MAG) ? NEG_MAG[WORD_BITS-1:0]
                                       : WORD_BITS'(-v[WORD_BITS-1:0]);
      else
        out_nxt.result = (v > POS_MAX) ? POS_MAX[WORD_BITS-1:0] : v[WORD_BITS-1:0];
    end else begin
      out_nxt.result = st_r[LAST-1].res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < LAST; k++) st_r[k] <= st_nxt[k];
      out_r <= out_nxt;
    end
  end

endmodule

// File: hw/rtl/fxalu_checker.sv
module fxalu_checker
  import fxalu_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Exactly one compare flag describes any pair of operands.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.less, out_data.equal, out_data.greater}))
    else $error("compare flags not one-hot");

  // A divide by zero always returns zero.
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_by_zero) |-> (out_data.result == '0))
    else $error("divide by zero with non-zero result");

  // An untaken result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Input is taken whenever the output side is free.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind fixed_point_q24_8_alu_unit fxalu_checker u_fxalu_checker (.*);
